[hdl/welford_three_axis_baseline_rms_unit_assert.svh]
// Assertion macros for the baseline rms unit.
`ifndef WELFORD_THREE_AXIS_BASELINE_RMS_UNIT_ASSERT_SVH
`define WELFORD_THREE_AXIS_BASELINE_RMS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define WBR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("wbr assertion failed");
`define WBR_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("wbr reset assertion failed");
`else
`define WBR_ASSERT(lbl, prop)
`define WBR_ASSERT_RST(lbl, prop)
`endif
`endif

[hdl/wbr_pkg.sv]
// Types and constants shared by the baseline rms unit.
package wbr_pkg;
    localparam int CFG_IDX_BITS = 3;
    localparam int REG_BITS     = 24;
    localparam int FEAT_BITS    = 24;
    localparam int NORM_BITS    = 25;
    localparam int WCNT_BITS    = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFF_X  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFF_Y  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFF_Z  = 3'd5;

    typedef enum logic [1:0] {
        ALU_DIV,
        ALU_MUL,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        logic        start;
        t_alu_op     op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] res;
    } t_alu_stat;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MDIV,
        ST_MDIV_W,
        ST_MMUL,
        ST_MMUL_W,
        ST_VDIV,
        ST_VDIV_W,
        ST_DMUL,
        ST_DMUL_W,
        ST_RSQ,
        ST_RSQ_W,
        ST_NMUL,
        ST_NMUL_W,
        ST_NSQ,
        ST_NSQ_W,
        ST_EMIT
    } t_state;
endpackage

[hdl/wbr_in_if.sv]
// Sample channel: valid/ready with three axis samples and a window-end flag.
interface wbr_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
    logic                          window_end;

    modport source (output valid, sample_x, sample_y, sample_z, window_end, input ready);
    modport sink (input valid, sample_x, sample_y, sample_z, window_end, output ready);
endinterface

[hdl/wbr_out_if.sv]
// Feature channel: valid/ready with per-axis features, norm and window count.
interface wbr_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] feature_x;
    logic [23:0] feature_y;
    logic [23:0] feature_z;
    logic [24:0] feature_norm;
    logic [15:0] window_samples;

    modport source (output valid, feature_x, feature_y, feature_z, feature_norm,
                    window_samples, input ready);
    modport sink (input valid, feature_x, feature_y, feature_z, feature_norm,
                  window_samples, output ready);
endinterface

[hdl/welford_three_axis_baseline_rms_unit.sv]
// Top level: Welford statistics per axis and windowed baseline rms features.
// Per sample, each axis needs a 64-step divide for the mean update and a
// shift-add multiply of up to 33 steps for the spread update, all on one
// shared iterative unit. A window-end sample adds per axis a 64-step
// divide (only from two samples on), a multiply and a 32-step square root,
// then three multiplies of up to 24 steps and one square root for the norm.
// The unit takes no new sample until the previous one is fully processed;
// a finished result waits in the output register while sampling continues.
module welford_three_axis_baseline_rms_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    wbr_in_if.sink                             i_smp,
    wbr_out_if.source                          o_feat,
    input  logic                               i_cfg_we,
    input  logic [wbr_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [wbr_pkg::REG_BITS-1:0]       i_cfg_data
);
    import wbr_pkg::*;

    t_state                 r_state, n_state;
    logic [1:0]             r_axis, n_axis;
    logic [COUNT_BITS-1:0]  r_cnt, n_cnt;
    logic signed [31:0]     r_mean [3];
    logic signed [31:0]     n_mean [3];
    logic [63:0]            r_m2 [3];
    logic [63:0]            n_m2 [3];
    logic signed [15:0]     r_smp [3];
    logic signed [15:0]     n_smp [3];
    logic                   r_wend, n_wend;
    logic [32:0]            r_dxm, n_dxm;
    logic                   r_dxneg, n_dxneg;
    logic [63:0]            r_var, n_var;
    logic [FEAT_BITS-1:0]   r_feat [3];
    logic [FEAT_BITS-1:0]   n_feat [3];
    logic [63:0]            r_nsum, n_nsum;
    logic [NORM_BITS-1:0]   r_norm, n_norm;
    logic signed [REG_BITS-1:0] r_base [3];
    logic [REG_BITS-1:0]    r_off [3];
    logic                   r_ovalid, n_ovalid;
    logic [FEAT_BITS-1:0]   r_ofx, r_ofy, r_ofz, n_ofx, n_ofy, n_ofz;
    logic [NORM_BITS-1:0]   r_onorm, n_onorm;
    logic [WCNT_BITS-1:0]   r_ocnt, n_ocnt;

    t_alu_req               w_req;
    t_alu_stat              w_alu;

    logic signed [SAMPLE_BITS-1:0] w_raw [3];
    logic signed [31:0]     w_ext [3];
    logic signed [15:0]     w_sat [3];
    logic signed [31:0]     w_xq;
    logic signed [32:0]     w_dx;
    logic [32:0]            w_dxmag;
    logic signed [33:0]     w_qs;
    logic signed [32:0]     w_dm;
    logic [32:0]            w_dmmag;
    logic signed [31:0]     w_base32;
    logic [64:0]            w_sum;
    logic [31:0]            w_rms;
    logic [32:0]            w_rdiff;
    logic                   w_in_acc;
    logic                   w_out_free;
    logic [31:0]            w_cnt32;
    logic [FEAT_BITS-1:0]   w_fsel;

    wbr_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_stat  (w_alu)
    );

    assign w_raw[0] = i_smp.sample_x;
    assign w_raw[1] = i_smp.sample_y;
    assign w_raw[2] = i_smp.sample_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_ext[k] = 32'(w_raw[k]);
            if (w_ext[k] > 32'sd32767) begin
                w_sat[k] = 16'sh7fff;
            end else if (w_ext[k] < -32'sd32768) begin
                w_sat[k] = -16'sh8000;
            end else begin
                w_sat[k] = w_ext[k][15:0];
            end
        end
    end

    assign w_in_acc   = i_smp.valid && i_smp.ready;
    assign w_out_free = !r_ovalid || o_feat.ready;
    assign w_xq       = {r_smp[r_axis], 16'h0000};
    assign w_dx       = 33'(w_xq) - 33'(r_mean[r_axis]);
    assign w_dxmag    = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
    assign w_qs       = r_dxneg ? -$signed({1'b0, w_alu.res[32:0]})
                                : $signed({1'b0, w_alu.res[32:0]});
    assign w_base32   = {r_base[r_axis], 8'h00};
    assign w_dm       = 33'(r_mean[r_axis]) - 33'(w_base32);
    assign w_dmmag    = w_dm[32] ? 33'(-w_dm) : 33'(w_dm);
    assign w_rms      = w_alu.res[31:0];
    assign w_rdiff    = {1'b0, w_rms} - {9'b0, r_off[r_axis]};
    assign w_cnt32    = 32'(r_cnt);
    assign w_fsel     = r_feat[r_axis];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_in_acc) n_state = ST_MDIV;
            ST_MDIV:   n_state = ST_MDIV_W;
            ST_MDIV_W: if (w_alu.done) n_state = ST_MMUL;
            ST_MMUL:   n_state = ST_MMUL_W;
            ST_MMUL_W: begin
                if (w_alu.done) begin
                    if (r_axis != 2'd2) n_state = ST_MDIV;
                    else if (r_wend)    n_state = ST_VDIV;
                    else                n_state = ST_IDLE;
                end
            end
            ST_VDIV:   n_state = (r_cnt >= COUNT_BITS'(2)) ? ST_VDIV_W : ST_DMUL;
            ST_VDIV_W: if (w_alu.done) n_state = ST_DMUL;
            ST_DMUL:   n_state = ST_DMUL_W;
            ST_DMUL_W: if (w_alu.done) n_state = ST_RSQ;
            ST_RSQ:    n_state = ST_RSQ_W;
            ST_RSQ_W: begin
                if (w_alu.done) n_state = (r_axis == 2'd2) ? ST_NMUL : ST_VDIV;
            end
            ST_NMUL:   n_state = ST_NMUL_W;
            ST_NMUL_W: begin
                if (w_alu.done) n_state = (r_axis == 2'd2) ? ST_NSQ : ST_NMUL;
            end
            ST_NSQ:    n_state = ST_NSQ_W;
            ST_NSQ_W:  if (w_alu.done) n_state = ST_EMIT;
            ST_EMIT:   if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // unit requests and handshake
    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = ALU_MUL;
        w_req.a     = '0;
        w_req.b     = '0;
        i_smp.ready = 1'b0;
        case (r_state)
            ST_IDLE: i_smp.ready = 1'b1;
            ST_MDIV: begin
                w_req.start = 1'b1;
                w_req.op    = ALU_DIV;
                w_req.a     = 64'(w_dxmag);
                w_req.b     = 64'(r_cnt);
            end
            ST_MMUL: begin
                w_req.start = 1'b1;
                w_req.a     = 64'(r_dxm);
                w_req.b     = 64'(w_dxmag);
            end
            ST_VDIV: begin
                w_req.start = (r_cnt >= COUNT_BITS'(2));
                w_req.op    = ALU_DIV;
                w_req.a     = r_m2[r_axis];
                w_req.b     = 64'(r_cnt - COUNT_BITS'(1));
            end
            ST_DMUL: begin
                w_req.start = 1'b1;
                w_req.a     = 64'(w_dmmag);
                w_req.b     = 64'(w_dmmag);
            end
            ST_RSQ: begin
                w_req.start = 1'b1;
                w_req.op    = ALU_SQRT;
                w_req.a     = r_var;
            end
            ST_NMUL: begin
                w_req.start = 1'b1;
                w_req.a     = 64'(w_fsel);
                w_req.b     = 64'(w_fsel);
            end
            ST_NSQ: begin
                w_req.start = 1'b1;
                w_req.op    = ALU_SQRT;
                w_req.a     = r_nsum;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_axis   = r_axis;
        n_cnt    = r_cnt;
        n_mean   = r_mean;
        n_m2     = r_m2;
        n_smp    = r_smp;
        n_wend   = r_wend;
        n_dxm    = r_dxm;
        n_dxneg  = r_dxneg;
        n_var    = r_var;
        n_feat   = r_feat;
        n_nsum   = r_nsum;
        n_norm   = r_norm;
        n_ovalid = r_ovalid && !o_feat.ready;
        n_ofx    = r_ofx;
        n_ofy    = r_ofy;
        n_ofz    = r_ofz;
        n_onorm  = r_onorm;
        n_ocnt   = r_ocnt;
        w_sum    = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_smp  = w_sat;
                    n_wend = i_smp.window_end;
                    n_axis = 2'd0;
                    if (r_cnt != '1) n_cnt = r_cnt + COUNT_BITS'(1);
                end
            end
            ST_MDIV: begin
                n_dxm   = w_dxmag;
                n_dxneg = w_dx[32];
            end
            ST_MDIV_W: begin
                if (w_alu.done) begin
                    n_mean[r_axis] = 32'(34'(r_mean[r_axis]) + w_qs);
                end
            end
            ST_MMUL_W: begin
                if (w_alu.done) begin
                    w_sum = {1'b0, r_m2[r_axis]} + {17'b0, w_alu.res[63:16]};
                    n_m2[r_axis] = w_sum[64] ? '1 : w_sum[63:0];
                    n_axis = (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                end
            end
            ST_VDIV: begin
                if (r_cnt < COUNT_BITS'(2)) n_var = '0;
            end
            ST_VDIV_W: begin
                if (w_alu.done) n_var = w_alu.res;
            end
            ST_DMUL_W: begin
                if (w_alu.done) begin
                    w_sum = {1'b0, r_var} + {17'b0, w_alu.res[63:16]};
                    n_var = w_sum[64] ? '1 : w_sum[63:0];
                end
            end
            ST_RSQ_W: begin
                if (w_alu.done) begin
                    if (w_rms <= 32'(r_off[r_axis])) begin
                        n_feat[r_axis] = '0;
                    end else if (w_rdiff > 33'h0_00FF_FFFF) begin
                        n_feat[r_axis] = '1;
                    end else begin
                        n_feat[r_axis] = w_rdiff[FEAT_BITS-1:0];
                    end
                    n_axis = (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                    n_nsum = '0;
                end
            end
            ST_NMUL_W: begin
                if (w_alu.done) begin
                    n_nsum = r_nsum + w_alu.res;
                    n_axis = (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                end
            end
            ST_NSQ_W: begin
                if (w_alu.done) n_norm = w_alu.res[NORM_BITS-1:0];
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ofx    = r_feat[0];
                    n_ofy    = r_feat[1];
                    n_ofz    = r_feat[2];
                    n_onorm  = r_norm;
                    n_ocnt   = (w_cnt32 > 32'd65535) ? '1 : w_cnt32[WCNT_BITS-1:0];
                    n_cnt    = '0;
                    for (int k = 0; k < 3; k++) begin
                        n_mean[k] = '0;
                        n_m2[k]   = '0;
                    end
                end
            end
            default: begin
                n_axis = r_axis;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_axis   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_mean[k] <= '0;
                r_m2[k]   <= '0;
                r_base[k] <= '0;
                r_off[k]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_axis   <= n_axis;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_mean   <= n_mean;
            r_m2     <= n_m2;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_X: r_base[0] <= i_cfg_data;
                    CFG_BASE_Y: r_base[1] <= i_cfg_data;
                    CFG_BASE_Z: r_base[2] <= i_cfg_data;
                    CFG_OFF_X:  r_off[0]  <= i_cfg_data;
                    CFG_OFF_Y:  r_off[1]  <= i_cfg_data;
                    CFG_OFF_Z:  r_off[2]  <= i_cfg_data;
                    default:    r_off[0]  <= r_off[0];
                endcase
            end
        end
        r_smp   <= n_smp;
        r_wend  <= n_wend;
        r_dxm   <= n_dxm;
        r_dxneg <= n_dxneg;
        r_var   <= n_var;
        r_feat  <= n_feat;
        r_nsum  <= n_nsum;
        r_norm  <= n_norm;
        r_ofx   <= n_ofx;
        r_ofy   <= n_ofy;
        r_ofz   <= n_ofz;
        r_onorm <= n_onorm;
        r_ocnt  <= n_ocnt;
    end

    assign o_feat.valid          = r_ovalid;
    assign o_feat.feature_x      = r_ofx;
    assign o_feat.feature_y      = r_ofy;
    assign o_feat.feature_z      = r_ofz;
    assign o_feat.feature_norm   = r_onorm;
    assign o_feat.window_samples = r_ocnt;

`include "welford_three_axis_baseline_rms_unit_assert.svh"

    `WBR_ASSERT(a_busy_after_beat, w_in_acc |=> !i_smp.ready)
    `WBR_ASSERT(a_no_restart, (w_req.start && w_alu.busy) |-> 1'b0)
    `WBR_ASSERT(a_count_live, (r_state != ST_IDLE && r_state != ST_EMIT) |-> (r_cnt != '0))
    `WBR_ASSERT_RST(a_rst_out, !i_rst_n |=> !o_feat.valid)
endmodule

[hdl/wbr_alu.sv]
// Shared iterative unit: restoring divide, shift-add multiply, integer sqrt.
module wbr_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wbr_pkg::t_alu_req i_req,
    output wbr_pkg::t_alu_stat o_stat
);
    import wbr_pkg::*;

    localparam int CNT_BITS = 7;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    t_alu_op             r_op, n_op;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [63:0]         r_acc, n_acc;
    logic [63:0]         r_x, n_x;
    logic [63:0]         r_y, n_y;
    logic [64:0]         w_rem;
    logic [63:0]         w_t;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        w_rem  = {r_acc, r_x[63]};
        w_t    = r_x + r_y;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = CNT_BITS'(64);
            case (i_req.op)
                ALU_DIV: begin
                    n_acc = '0;
                    n_x   = i_req.a;
                    n_y   = i_req.b;
                end
                ALU_MUL: begin
                    n_acc = '0;
                    n_x   = i_req.a;
                    n_y   = i_req.b;
                end
                ALU_SQRT: begin
                    n_acc = i_req.a;
                    n_x   = '0;
                    n_y   = 64'h4000_0000_0000_0000;
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end else if (r_busy) begin
            case (r_op)
                ALU_DIV: begin
                    if (w_rem >= {1'b0, r_y}) begin
                        n_acc = 64'(w_rem - {1'b0, r_y});
                        n_x   = {r_x[62:0], 1'b1};
                    end else begin
                        n_acc = w_rem[63:0];
                        n_x   = {r_x[62:0], 1'b0};
                    end
                    n_cnt = r_cnt - CNT_BITS'(1);
                    if (r_cnt == CNT_BITS'(1)) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
                ALU_MUL: begin
                    if (r_y == '0) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end else begin
                        if (r_y[0]) begin
                            n_acc = r_acc + r_x;
                        end
                        n_x = {r_x[62:0], 1'b0};
                        n_y = {1'b0, r_y[63:1]};
                    end
                end
                ALU_SQRT: begin
                    if (r_acc >= w_t) begin
                        n_acc = r_acc - w_t;
                        n_x   = {1'b0, r_x[63:1]} + r_y;
                    end else begin
                        n_x = {1'b0, r_x[63:1]};
                    end
                    n_y = {2'b00, r_y[63:2]};
                    if (r_y == 64'd1) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ALU_DIV;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.res  = (r_op == ALU_MUL) ? r_acc : r_x;
endmodule

[tb/wbr_feature_checker.sv]
// Feature checker: predicts windowed baseline rms features and compares them with the output.
`timescale 1ns / 100ps
module wbr_feature_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    wbr_in_if                                smp,
    wbr_out_if                               feat,
    input  logic                             i_cfg_we,
    input  logic [wbr_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [wbr_pkg::REG_BITS-1:0]     i_cfg_data,
    output int                               o_fails,
    output int                               o_pending
);
    import wbr_pkg::*;

    localparam longint COUNT_MAX = 65535;

    typedef struct packed {
        logic [23:0] fx;
        logic [23:0] fy;
        logic [23:0] fz;
        logic [24:0] norm;
        logic [15:0] nsamp;
    } t_feat;

    t_feat       feat_q[$];
    logic signed [23:0] bl_mean[3];
    logic [23:0] base_off[3];
    longint      win_count;
    longint      run_mean[3];
    logic [63:0] spread[3];
    int          fails;

    assign o_fails   = fails;
    assign o_pending = feat_q.size();

    function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] abs64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [23:0] axis_rms(int a);
        logic [63:0] var_q;
        logic [63:0] dm;
        logic [63:0] rms;
        logic [63:0] res;
        var_q = (win_count >= 2) ? spread[a] / 64'(win_count - 1) : 64'd0;
        dm    = abs64(run_mean[a] - longint'(bl_mean[a]) * 256);
        rms   = int_sqrt(sum_sat(var_q, (dm * dm) >> 16));
        res   = (rms > 64'(base_off[a])) ? rms - 64'(base_off[a]) : 64'd0;
        return (res > 64'hFFFFFF) ? 24'hFFFFFF : res[23:0];
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fails++;
    endtask

    task automatic take_sample(logic signed [15:0] s[3], logic wend);
        longint xq;
        longint dx;
        longint dx2;
        t_feat  f;
        logic [63:0] sq;
        if (win_count < COUNT_MAX) win_count++;
        for (int a = 0; a < 3; a++) begin
            xq  = longint'(s[a]) * 65536;
            dx  = xq - run_mean[a];
            run_mean[a] += dx / win_count;
            dx2 = xq - run_mean[a];
            spread[a] = sum_sat(spread[a], (abs64(dx) * abs64(dx2)) >> 16);
        end
        if (wend) begin
            f.fx    = axis_rms(0);
            f.fy    = axis_rms(1);
            f.fz    = axis_rms(2);
            sq      = 64'(f.fx) * f.fx + 64'(f.fy) * f.fy + 64'(f.fz) * f.fz;
            sq      = int_sqrt(sq);
            f.norm  = sq[24:0];
            f.nsamp = (win_count > 65535) ? 16'hFFFF : win_count[15:0];
            feat_q.push_back(f);
            win_count = 0;
            for (int a = 0; a < 3; a++) begin
                run_mean[a] = 0;
                spread[a]   = 0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        logic signed [15:0] s[3];
        t_feat w;
        if (!i_rst_n) begin
            feat_q.delete();
            win_count = 0;
            for (int a = 0; a < 3; a++) begin
                bl_mean[a]   = 0;
                base_off[a]  = 0;
                run_mean[a]  = 0;
                spread[a]    = 0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_X: bl_mean[0]  = i_cfg_data;
                    CFG_BASE_Y: bl_mean[1]  = i_cfg_data;
                    CFG_BASE_Z: bl_mean[2]  = i_cfg_data;
                    CFG_OFF_X:  base_off[0] = i_cfg_data;
                    CFG_OFF_Y:  base_off[1] = i_cfg_data;
                    CFG_OFF_Z:  base_off[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (smp.valid && smp.ready) begin
                s[0] = smp.sample_x;
                s[1] = smp.sample_y;
                s[2] = smp.sample_z;
                take_sample(s, smp.window_end);
            end
            if (feat.valid && feat.ready) begin
                if (feat_q.size() == 0) begin
                    report("unexpected beat", 1, 0);
                end else begin
                    w = feat_q.pop_front();
                    if (feat.feature_x != w.fx) report("feature_x", feat.feature_x, w.fx);
                    if (feat.feature_y != w.fy) report("feature_y", feat.feature_y, w.fy);
                    if (feat.feature_z != w.fz) report("feature_z", feat.feature_z, w.fz);
                    if (feat.feature_norm != w.norm)
                        report("feature_norm", feat.feature_norm, w.norm);
                    if (feat.window_samples != w.nsamp)
                        report("window_samples", feat.window_samples, w.nsamp);
                end
            end
        end
    end

    initial fails = 0;
endmodule

[tb/tb_welford_three_axis_baseline_rms_unit.sv]
// Testbench top: drives samples and register writes into the baseline rms unit.
`timescale 1ns / 100ps
module tb_welford_three_axis_baseline_rms_unit;
    import wbr_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 3'd7;
    localparam int SETTLE_CYCLES = 1500;
    localparam longint CYCLE_LIMIT = 6000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [REG_BITS-1:0]     cfg_data;
    int          fails;
    int          pending;
    int          send_idle;
    int          recv_idle;
    logic        hold_req;
    logic        hold_done;
    int          hold_left;
    longint      cycles;

    wbr_in_if #(.SAMPLE_BITS(16)) smp ();
    wbr_out_if feat ();

    welford_three_axis_baseline_rms_unit #(.SAMPLE_BITS(16), .COUNT_BITS(16)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_smp(smp), .o_feat(feat),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    wbr_feature_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .smp(smp), .feat(feat),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fails(fails), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            feat.ready <= 1'b0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            feat.ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left  <= 6000;
            hold_done  <= 1'b1;
            feat.ready <= 1'b0;
        end else begin
            feat.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send(logic signed [15:0] x, logic signed [15:0] y,
                        logic signed [15:0] z, logic wend);
        while ($urandom_range(99) < send_idle) begin
            smp.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp.valid      <= 1'b1;
        smp.sample_x   <= x;
        smp.sample_y   <= y;
        smp.sample_z   <= z;
        smp.window_end <= wend;
        do @(posedge i_clk); while (!smp.ready);
    endtask

    task automatic drain();
        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [23:0] bx, logic [23:0] by, logic [23:0] bz,
                            logic [23:0] ox, logic [23:0] oy, logic [23:0] oz);
        logic [CFG_IDX_BITS-1:0] idx[8];
        logic [23:0] val[8];
        idx = '{CFG_BASE_X, CFG_BASE_Y, CFG_BASE_Z, CFG_OFF_X, CFG_OFF_Y, CFG_OFF_Z,
                CFG_SPARE_A, CFG_SPARE_B};
        val = '{bx, by, bz, ox, oy, oz, 24'($urandom), 24'($urandom)};
        for (int i = 0; i < 8; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idx[i];
            cfg_data <= val[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick(int style, int center);
        case (style)
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'(center + int'($urandom_range(64)) - 32);
        endcase
    endfunction

    task automatic random_windows(int n_items);
        int sent;
        int len;
        int style;
        int cx, cy, cz;
        sent = 0;
        while (sent < n_items) begin
            len   = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
            style = $urandom_range(3);
            cx = int'($urandom_range(65535)) - 32768;
            cy = int'($urandom_range(65535)) - 32768;
            cz = int'($urandom_range(65535)) - 32768;
            for (int i = 0; i < len; i++) begin
                send(pick(style, cx), pick(style, cy), pick(style, cz),
                     (i == len - 1) || ($urandom_range(49) == 0));
                sent++;
            end
        end
    endtask

    task automatic random_regs();
        set_regs(24'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom_range(3000)), 24'($urandom_range(1 << 16)),
                 $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(500)));
    endtask

    initial begin
        cycles         = 0;
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= '0;
        cfg_data      <= '0;
        smp.valid     <= 1'b0;
        smp.sample_x  <= '0;
        smp.sample_y  <= '0;
        smp.sample_z  <= '0;
        smp.window_end <= 1'b0;
        hold_req      <= 1'b0;
        send_idle      = 0;
        recv_idle      = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, single, two and six sample windows, reset registers
        send(16'sh7FFF, 16'sh8000, 16'sh0000, 1'b1);
        send(16'sh8000, 16'sh7FFF, 16'shFFFF, 1'b1);
        send(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        send(16'sh0001, 16'shAAAA, 16'sh5555, 1'b0);
        send(16'sh0001, 16'sh5555, 16'shAAAA, 1'b1);
        for (int i = 0; i < 6; i++)
            send(i[0] ? 16'sh7FFF : 16'sh8000, 16'sh0100, 16'(i * 3), i == 5);
        drain();
        // max baseline against negative samples: feature saturates
        set_regs(24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000, 24'h000000, 24'h000100);
        send(16'sh8000, 16'sh7FFF, 16'sh0000, 1'b1);
        send(16'sh8000, 16'sh7FFF, 16'sh1234, 1'b0);
        send(16'sh8000, 16'sh7FFF, 16'sh1234, 1'b1);
        drain();
        // offset above rms: features zero
        set_regs(24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1);
        send(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
        send(16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b1);
        drain();

        // receiver holds off while samples keep coming
        random_regs();
        hold_req <= 1'b1;
        for (int i = 0; i < 20; i++)
            send(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        drain();

        for (int mode = 0; mode < 3; mode++) begin
            send_idle = (mode == 0) ? 27 : (mode == 1) ? 48 : 0;
            recv_idle = (mode == 0) ? 48 : (mode == 1) ? 27 : 0;
            for (int ph = 0; ph < 3; ph++) begin
                if (mode == 2 && ph == 2)
                    set_regs(24'h800000, 24'h7FFFFF, 24'h000000,
                             24'h000000, 24'hFFFFFF, 24'h000000);
                else
                    random_regs();
                random_windows(195);
                drain();
            end
        end

        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
